// ----- hdl/mfd_pkg.sv -----
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared constants, codes and types of the multiplexed frame deframer.
// ----------------------------------------------------------------------------
package mfd_pkg;

	localparam int CHANNELS     = 16;
	localparam int HEADER_BYTES = 6;
	localparam int PAD_UNIT     = 12;
	localparam int MAX_PAYLOAD  = 246;
	localparam int FIFO_DEPTH   = 4;

	localparam int CNT_W   = $clog2(MAX_PAYLOAD + HEADER_BYTES + PAD_UNIT);
	localparam int PAD_W   = $clog2(PAD_UNIT + 1);
	localparam int HDR_PAD = HEADER_BYTES % PAD_UNIT;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_EMPTY = 2'd1;
	localparam logic [1:0] KIND_ERR   = 2'd2;

	localparam logic REG_MAX_PAYLOAD = 1'b0;
	localparam logic REG_CHAN_EN     = 1'b1;

	typedef struct packed {
		logic [7:0]  max_payload;
		logic [15:0] channel_enable;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  chan;
		logic [7:0]  data;
		logic        last;
		logic        first;
		logic [15:0] sum;
	} token_t;

endpackage

// ----- hdl/mfd_parser.sv -----
// ----------------------------------------------------------------------------
// mfd_parser
// Front end: assembles headers, tracks payload and padding, and turns each
// received byte into zero or one result token.
// ----------------------------------------------------------------------------
module mfd_parser import mfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       byte_valid,
	input  logic [7:0] rx_byte,
	output logic       tok_valid,
	output token_t     tok
);

	typedef enum logic [1:0] {PH_HEADER, PH_PAYLOAD, PH_PAD} phase_t;

	phase_t             phase_q;
	logic [47:0]        hdr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PAD_W-1:0]   pad_q;
	logic               known_q;

	logic [2:0]         hdr_idx;
	logic [CNT_W-1:0]   cnt_inc;
	logic [PAD_W-1:0]   pad_inc;
	logic [15:0]        len;
	logic [15:0]        ch;
	logic [15:0]        sum_hdr;
	logic               len_bad;
	logic               known_now;
	logic               pay_last;
	logic               hdr_done;

	always_comb begin
		hdr_idx   = cnt_q[2:0];
		hdr_done  = (hdr_idx == 3'(HEADER_BYTES - 1));
		cnt_inc   = cnt_q + CNT_W'(1);
		pad_inc   = (pad_q == PAD_W'(PAD_UNIT - 1)) ? '0 : pad_q + PAD_W'(1);
		ch        = hdr_q[15:0];
		len       = hdr_q[31:16];
		sum_hdr   = {rx_byte, hdr_q[39:32]};
		len_bad   = (len > {8'd0, cfg.max_payload}) || (len > 16'(MAX_PAYLOAD));
		known_now = (ch < 16'(CHANNELS)) && (ch < 16'd16) && cfg.channel_enable[ch[3:0]];
		pay_last  = cnt_inc >= (CNT_W'(len) + CNT_W'(HEADER_BYTES));

		tok_valid = 1'b0;
		tok.kind  = KIND_BYTE;
		tok.chan  = hdr_q[3:0];
		tok.data  = 8'd0;
		tok.last  = 1'b0;
		tok.first = 1'b0;
		tok.sum   = hdr_q[47:32];
		case (phase_q)
			PH_HEADER: begin
				if (hdr_done) begin
					if (len_bad) begin
						tok_valid = byte_valid;
						tok.kind  = KIND_ERR;
					end else if (len == 16'd0 && known_now) begin
						tok_valid = byte_valid;
						tok.kind  = KIND_EMPTY;
						tok.last  = 1'b1;
						tok.first = 1'b1;
						tok.sum   = sum_hdr;
					end
				end
			end
			PH_PAYLOAD: begin
				tok_valid = byte_valid && known_q;
				tok.data  = rx_byte;
				tok.last  = pay_last;
				tok.first = (cnt_q == CNT_W'(HEADER_BYTES));
			end
			default: begin
				tok_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_q   <= '0;
			cnt_q   <= '0;
			pad_q   <= '0;
			known_q <= 1'b0;
		end else if (byte_valid) begin
			case (phase_q)
				PH_HEADER: begin
					hdr_q[{hdr_idx, 3'b000} +: 8] <= rx_byte;
					if (hdr_done) begin
						if (len_bad) begin
							cnt_q <= '0;
						end else begin
							known_q <= known_now;
							pad_q   <= PAD_W'(HDR_PAD);
							if (len != 16'd0) begin
								phase_q <= PH_PAYLOAD;
								cnt_q   <= cnt_inc;
							end else if (HDR_PAD == 0) begin
								cnt_q <= '0;
							end else begin
								phase_q <= PH_PAD;
								cnt_q   <= cnt_inc;
							end
						end
					end else begin
						cnt_q <= cnt_inc;
					end
				end
				PH_PAYLOAD: begin
					cnt_q <= cnt_inc;
					pad_q <= pad_inc;
					if (pay_last) begin
						if (pad_inc == '0) begin
							phase_q <= PH_HEADER;
							cnt_q   <= '0;
						end else begin
							phase_q <= PH_PAD;
						end
					end
				end
				PH_PAD: begin
					cnt_q <= cnt_inc;
					pad_q <= pad_inc;
					if (pad_inc == '0) begin
						phase_q <= PH_HEADER;
						cnt_q   <= '0;
					end
				end
				default: begin
					phase_q <= PH_HEADER;
					cnt_q   <= '0;
				end
			endcase
		end
	end

endmodule

// ----- hdl/mfd_fifo.sv -----
// ----------------------------------------------------------------------------
// mfd_fifo
// Short token queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module mfd_fifo import mfd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  token_t wr_tok,
	output logic   full,
	input  logic   rd_en,
	output token_t rd_tok,
	output logic   empty
);

	localparam int PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

	token_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full   = (count_q == FCNT_W'(FIFO_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_tok = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + FCNT_W'(1);
				2'b01:   count_q <= count_q - FCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hdl/mfd_emitter.sv -----
// ----------------------------------------------------------------------------
// mfd_emitter
// Back end: keeps the payload byte sum, checks it on the last word and holds
// the result word for the consumer.
// ----------------------------------------------------------------------------
module mfd_emitter import mfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tok_empty,
	input  token_t     tok,
	output logic       tok_pop,
	input  logic       pop,
	output logic       empty,
	output logic [1:0] kind,
	output logic [3:0] chan,
	output logic [7:0] data,
	output logic       last,
	output logic       checksum_ok
);

	logic        valid_q;
	logic [15:0] acc_q;
	logic [1:0]  kind_q;
	logic [3:0]  chan_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic        ok_q;
	logic [15:0] acc_next;

	assign tok_pop  = !tok_empty && (!valid_q || pop);
	assign acc_next = (tok.first ? 16'd0 : acc_q) + {8'd0, tok.data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			acc_q   <= '0;
		end else if (tok_pop) begin
			valid_q <= 1'b1;
			acc_q   <= acc_next;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_pop) begin
			kind_q <= tok.kind;
			chan_q <= tok.chan;
			data_q <= tok.data;
			last_q <= tok.last;
			ok_q   <= tok.last && (acc_next == tok.sum);
		end
	end

	assign empty       = !valid_q;
	assign kind        = kind_q;
	assign chan        = chan_q;
	assign data        = data_q;
	assign last        = last_q;
	assign checksum_ok = ok_q;

endmodule

// ----- hdl/mux_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// mux_frame_deframer
// Byte-serial parser for multiplexed link frames with per-channel tagging.
// ----------------------------------------------------------------------------
// Takes one received byte per clock while full is low. Each byte is
// classified by the parser in the cycle it is accepted and any result is
// queued in a four-word token queue; the result stage moves one word per
// cycle into the output register while it is free or popped, and a result
// is registered in the token queue and then in the output register.
// full rises only when the token queue is full, which happens when the
// consumer holds pop low. Frames are a 6-byte little-endian header (channel,
// length, checksum), the payload and padding to a multiple of 12 bytes.
// Register 0 is max_payload (reset 246), register 1 is channel_enable
// (reset 3); write them only while idle.
// ----------------------------------------------------------------------------
module mux_frame_deframer import mfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [3:0]  chan,
	output logic [7:0]  data,
	output logic        last,
	output logic        checksum_ok,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t   cfg_q;
	logic   accept;
	logic   tok_valid;
	token_t tok_in;
	token_t tok_out;
	logic   tok_empty;
	logic   tok_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_payload    <= 8'd246;
			cfg_q.channel_enable <= 16'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_PAYLOAD: cfg_q.max_payload    <= cfg_data[7:0];
				REG_CHAN_EN:     cfg_q.channel_enable <= cfg_data;
				default:         cfg_q                <= cfg_q;
			endcase
		end
	end

	assign accept = push && !full;

	mfd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (accept),
		.rx_byte    (rx_byte),
		.tok_valid  (tok_valid),
		.tok        (tok_in)
	);

	mfd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (tok_valid),
		.wr_tok (tok_in),
		.full   (full),
		.rd_en  (tok_pop),
		.rd_tok (tok_out),
		.empty  (tok_empty)
	);

	mfd_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok_empty   (tok_empty),
		.tok         (tok_out),
		.tok_pop     (tok_pop),
		.pop         (pop),
		.empty       (empty),
		.kind        (kind),
		.chan        (chan),
		.data        (data),
		.last        (last),
		.checksum_ok (checksum_ok)
	);

endmodule

// ----- hdl/mfd_checker.sv -----
// ----------------------------------------------------------------------------
// mfd_checker
// Port-level checks on the result side of the frame deframer.
// ----------------------------------------------------------------------------
module mfd_checker import mfd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] kind,
	input logic [7:0] data,
	input logic       last,
	input logic       checksum_ok
);

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (kind == KIND_BYTE || kind == KIND_EMPTY || kind == KIND_ERR))
		else $error("illegal result kind");

	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_ERR) |-> (!last && !checksum_ok && data == 8'd0))
		else $error("length error word carries payload fields");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_EMPTY) |-> (last && data == 8'd0))
		else $error("empty frame word malformed");

	a_ok_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !last) |-> !checksum_ok)
		else $error("checksum flag set before last word");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(data) && $stable(last)))
		else $error("result word changed while stalled");

endmodule

bind mux_frame_deframer mfd_checker u_mfd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.kind        (kind),
	.data        (data),
	.last        (last),
	.checksum_ok (checksum_ok)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multiplexed frame deframer.
// ----------------------------------------------------------------------------
// Feeds link bytes built into frames: good and bad checksums, empty frames,
// unknown and negative channels, oversized lengths and stray noise bytes.
// A byte-level parser model predicts every output word, and each popped word
// is compared field by field with the oldest prediction. Both handshakes
// stall in random bursts; the registers are rewritten between traffic
// phases while nothing is in flight.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mfd_pkg::*;

	localparam int LIMIT_CYCLES = 400000;

	typedef enum logic [1:0] {IN_HEADER, IN_PAYLOAD, IN_PAD} parse_phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [3:0] chan;
		logic [7:0] data;
		logic       last;
		logic       ok;
	} word_t;

	class frame_scoreboard;
		word_t        expected[$];
		int           errors;
		int           max_pay;
		logic [15:0]  chan_en;
		parse_phase_t ph;
		logic [47:0]  hdr;
		int           cnt;
		logic [15:0]  run_sum;
		int           total;
		bit           known;

		function new();
			errors  = 0;
			max_pay = 246;
			chan_en = 16'h0003;
			ph      = IN_HEADER;
			hdr     = '0;
			cnt     = 0;
			run_sum = '0;
			total   = 0;
			known   = 0;
		endfunction

		function void write_reg(logic idx, logic [15:0] val);
			if (idx == REG_MAX_PAYLOAD) begin
				max_pay = int'(val[7:0]);
			end else begin
				chan_en = val;
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void add(logic [1:0] k, logic [7:0] d, logic l, logic ok);
			word_t w;
			w.kind = k;
			w.chan = hdr[3:0];
			w.data = d;
			w.last = l;
			w.ok   = ok;
			expected.push_back(w);
		endfunction

		function void note_byte(logic [7:0] b);
			int  pos;
			int  chn;
			int  len;
			int  csum;
			bit  is_last;
			case (ph)
				IN_HEADER: begin
					pos = (cnt < HEADER_BYTES) ? cnt : 0;
					hdr[pos*8 +: 8] = b;
					cnt = pos + 1;
					if (cnt >= HEADER_BYTES) begin
						chn  = int'(hdr[15:0]);
						len  = int'(hdr[31:16]);
						csum = int'(hdr[47:32]);
						if (len > max_pay || len > MAX_PAYLOAD) begin
							add(KIND_ERR, 8'h00, 1'b0, 1'b0);
							cnt = 0;
						end else begin
							// negative channels land above 32767 here
							known   = (chn < CHANNELS && chn < 16) ? chan_en[chn] : 1'b0;
							total   = (len + HEADER_BYTES + PAD_UNIT - 1) / PAD_UNIT * PAD_UNIT;
							run_sum = '0;
							if (len == 0) begin
								if (known)
									add(KIND_EMPTY, 8'h00, 1'b1, csum == 0);
								if (cnt >= total) begin
									cnt = 0;
								end else begin
									ph = IN_PAD;
								end
							end else begin
								ph = IN_PAYLOAD;
							end
						end
					end
				end
				IN_PAYLOAD: begin
					len     = int'(hdr[31:16]);
					run_sum = run_sum + 16'(b);
					cnt     = cnt + 1;
					is_last = cnt >= len + HEADER_BYTES;
					if (known)
						add(KIND_BYTE, b, is_last, is_last && run_sum == hdr[47:32]);
					if (is_last) begin
						if (cnt >= total) begin
							ph  = IN_HEADER;
							cnt = 0;
						end else begin
							ph = IN_PAD;
						end
					end
				end
				default: begin
					cnt = cnt + 1;
					if (cnt >= total) begin
						ph  = IN_HEADER;
						cnt = 0;
					end
				end
			endcase
		endfunction

		function void report(string fld, int want_v, int got_v);
			errors++;
			if (errors <= 100)
				$display("%0t: %s expected %0d actual %0d", $time, fld, want_v, got_v);
		endfunction

		function void check_word(logic [1:0] k, logic [3:0] c, logic [7:0] d,
			logic l, logic ok);
			word_t want;
			if (expected.size() == 0) begin
				errors++;
				if (errors <= 100)
					$display("%0t: word with none expected: kind %0d chan %0d data %0d",
						$time, k, c, d);
				return;
			end
			want = expected.pop_front();
			if (k != want.kind)
				report("kind", want.kind, k);
			if (c != want.chan)
				report("chan", want.chan, c);
			if (d != want.data)
				report("data", want.data, d);
			if (l != want.last)
				report("last", want.last, l);
			if (ok != want.ok)
				report("checksum_ok", want.ok, ok);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  rx_byte;
	logic        empty;
	logic        pop;
	logic [1:0]  kind;
	logic [3:0]  chan;
	logic [7:0]  data;
	logic        last;
	logic        checksum_ok;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	frame_scoreboard sb;
	bit tx_idle_en;
	bit rx_idle_en;
	int sent;
	int cycles;

	mux_frame_deframer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.chan        (chan),
		.data        (data),
		.last        (last),
		.checksum_ok (checksum_ok),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: random pop stalls
	initial begin
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				pop = 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				pop = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_word(kind, chan, data, last, checksum_ok);
	end

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			push = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		push    = 1'b1;
		rx_byte = b;
		do @(posedge clk); while (full);
		sb.note_byte(b);
		sent++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		push = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_regs(input int max_len, input logic [15:0] en);
		wait_idle();
		write_reg(REG_MAX_PAYLOAD, {8'($urandom), 8'(max_len)});
		write_reg(REG_CHAN_EN, en);
	endtask

	task automatic send_frame(input logic [15:0] chn, input logic [15:0] len,
		input bit bad_sum);
		logic [7:0]  pay[$];
		logic [15:0] csum;
		int          lim;
		int          tot;
		csum = '0;
		lim  = sb.max_pay < MAX_PAYLOAD ? sb.max_pay : MAX_PAYLOAD;
		if (int'(len) <= lim) begin
			for (int i = 0; i < int'(len); i++) begin
				pay.push_back(8'($urandom));
				csum = csum + 16'(pay[i]);
			end
		end
		if (bad_sum)
			csum = csum + 16'($urandom_range(1, 65535));
		send_byte(chn[7:0]);
		send_byte(chn[15:8]);
		send_byte(len[7:0]);
		send_byte(len[15:8]);
		send_byte(csum[7:0]);
		send_byte(csum[15:8]);
		// oversized frames go header only so that the parser stays in step
		if (int'(len) <= lim) begin
			foreach (pay[i])
				send_byte(pay[i]);
			tot = (int'(len) + HEADER_BYTES + PAD_UNIT - 1) / PAD_UNIT * PAD_UNIT;
			repeat (tot - HEADER_BYTES - int'(len)) send_byte(8'($urandom));
		end
	endtask

	task automatic run_traffic(input int n_bytes);
		int          stop_at;
		int          lim;
		int          r;
		logic [15:0] chn;
		logic [15:0] len;
		stop_at = sent + n_bytes;
		while (sent < stop_at) begin
			lim = sb.max_pay < MAX_PAYLOAD ? sb.max_pay : MAX_PAYLOAD;
			r   = $urandom_range(0, 99);
			if (r < 6) begin
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
			end else begin
				r = $urandom_range(0, 99);
				if (r < 75)
					chn = 16'($urandom_range(0, 15));
				else if (r < 90)
					chn = 16'($urandom);
				else
					chn = 16'h8000 | 16'($urandom);
				r = $urandom_range(0, 99);
				if (r < 3)
					len = 16'(lim + $urandom_range(1, 20));
				else if (r < 5)
					len = 16'($urandom);
				else if (r < 70)
					len = 16'($urandom_range(0, lim < 20 ? lim : 20));
				else if (r < 95)
					len = 16'($urandom_range(0, lim < 80 ? lim : 80));
				else
					len = 16'($urandom_range(0, lim));
				send_frame(chn, len, $urandom_range(0, 99) < 15);
			end
		end
	endtask

	initial begin
		push       = 1'b0;
		rx_byte    = '0;
		cfg_we     = 1'b0;
		cfg_index  = REG_MAX_PAYLOAD;
		cfg_data   = '0;
		arst_n     = 1'b0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		sent       = 0;
		sb         = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: channels 0 and 1, up to 246 bytes
		send_frame(16'd0, 16'd1, 1'b0);
		send_frame(16'd1, 16'd0, 1'b0);
		send_frame(16'd1, 16'd0, 1'b1);
		send_frame(16'd2, 16'd3, 1'b0);
		send_frame(16'hFFFF, 16'd2, 1'b0);
		send_frame(16'd0, 16'd6, 1'b1);
		send_frame(16'd1, 16'd246, 1'b0);
		send_frame(16'd0, 16'd247, 1'b0);
		send_frame(16'h8000, 16'hFFFF, 1'b0);

		set_regs(255, 16'hFFFF);
		send_frame(16'd15, 16'd2, 1'b0);
		send_frame(16'd16, 16'd1, 1'b0);
		send_frame(16'd7, 16'd247, 1'b0);
		send_frame(16'd9, 16'd246, 1'b1);

		set_regs(0, 16'h5555);
		send_frame(16'd2, 16'd0, 1'b0);
		send_frame(16'd3, 16'd0, 1'b0);
		send_frame(16'd2, 16'd1, 1'b0);

		set_regs(246, 16'hFFFF);
		run_traffic(200);
		set_regs(40, 16'($urandom));
		run_traffic(100);
		wait_idle();
		run_traffic(100);
		set_regs(255, 16'h8001);
		run_traffic(150);
		set_regs(0, 16'hFFFF);
		run_traffic(80);
		set_regs($urandom_range(0, 255), 16'($urandom));
		run_traffic(150);
		set_regs(246, 16'h0003);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		run_traffic(150);

		wait_idle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- mux_frame_deframer.f -----
hdl/mfd_pkg.sv
hdl/mfd_parser.sv
hdl/mfd_fifo.sv
hdl/mfd_emitter.sv
hdl/mux_frame_deframer.sv
hdl/mfd_checker.sv
sim/tb.sv
